/* rtl/hrt_pkg.sv */
`default_nettype none

package hrt_pkg;

    // Fixed field widths on the stream ports
    localparam int OP_W      = 2;
    localparam int BYTE_W    = 8;
    localparam int HANDLE_W  = 16;
    localparam int KEY_W     = 64;
    localparam int STATUS_W  = 2;

    // s_tdata: data_byte, handle, key (lowest first), 88 bits = 11 bytes
    localparam int S_TDATA_W = BYTE_W + HANDLE_W + KEY_W;
    // m_tdata: key_out, handle_out, 80 bits = 10 bytes
    localparam int M_TDATA_W = KEY_W + HANDLE_W;

    // Default configuration
    localparam int DEF_KEY_BITS    = 64;
    localparam int DEF_NODE_COUNT  = 1024;
    localparam int DEF_HANDLE_BITS = 16;

    // Trie fan-out: one nibble per level
    localparam int NIB_W = 4;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT   = 2'd0,
        OP_RETRIEVE = 2'd1,
        OP_DISCARD  = 2'd2
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_EXISTS    = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_POOL_FULL = 2'd3
    } status_t;

    typedef struct packed {
        logic [KEY_W-1:0]    key;
        logic [HANDLE_W-1:0] handle;
        status_t             status;
    } result_t;

endpackage

`default_nettype wire

/* rtl/hrt_ram.sv */
`default_nettype none

module hrt_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 16,
    localparam int AW    = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* rtl/hrt_hash.sv */
`default_nettype none

module hrt_hash
    import hrt_pkg::*;
#(
    parameter int KEY_BITS = DEF_KEY_BITS
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                take,     // insert byte accepted
    input  wire logic                clear,    // final byte: restart
    input  wire logic [BYTE_W-1:0]   data_byte,
    output logic      [KEY_BITS-1:0] h_next
);

    logic [KEY_BITS-1:0] acc_reg;

    // 257*h + b = (h << 8 | b) + h; the low byte of h << 8 is zero
    assign h_next = ((acc_reg << 8) | KEY_BITS'(data_byte)) + acc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
        end else if (take) begin
            acc_reg <= clear ? '0 : h_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/hrt_walk.sv */
`default_nettype none

module hrt_walk
    import hrt_pkg::*;
#(
    parameter  int KEY_BITS    = DEF_KEY_BITS,
    parameter  int NODE_COUNT  = DEF_NODE_COUNT,
    parameter  int HANDLE_BITS = DEF_HANDLE_BITS,
    localparam int NODE_W      = $clog2(NODE_COUNT),
    localparam int AW          = NODE_W + NIB_W,
    localparam int VAL_W       = (NODE_W > HANDLE_BITS) ? NODE_W : HANDLE_BITS,
    localparam int EW          = VAL_W + 1
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    // command
    input  wire logic                   cmd_valid,
    output logic                        cmd_ready,
    input  wire op_t                    cmd_op,
    input  wire logic [KEY_BITS-1:0]    cmd_key,
    input  wire logic [HANDLE_BITS-1:0] cmd_handle,
    // result
    output logic                        res_valid,
    input  wire logic                   res_ready,
    output result_t                     res,
    // entry memory
    output logic                        ram_wr_en,
    output logic      [AW-1:0]          ram_wr_addr,
    output logic      [EW-1:0]          ram_wr_data,
    output logic      [AW-1:0]          ram_rd_addr,
    input  wire logic [EW-1:0]          ram_rd_data
);

    localparam int DEPTH  = NODE_COUNT * 16;
    localparam int LEVELS = (KEY_BITS - 1) / NIB_W;   // inner levels
    localparam int LW     = $clog2(LEVELS + 1);
    localparam int FW     = $clog2(NODE_COUNT + 1);
    localparam int HIN    = (HANDLE_BITS < HANDLE_W) ? HANDLE_BITS : HANDLE_W;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOKUP,
        S_RESULT
    } state_t;

    state_t                 state_reg, state_next;
    logic [LW-1:0]          lvl_reg, lvl_next;
    logic [NODE_W-1:0]      node_reg, node_next;
    logic [FW-1:0]          free_reg, free_next;
    logic [AW-1:0]          clr_addr_reg, clr_addr_next;
    logic [AW-1:0]          rd_addr_reg, rd_addr_next;
    logic [KEY_BITS-1:0]    key_reg, key_next;
    logic [HANDLE_BITS-1:0] handle_reg, handle_next;
    op_t                    op_reg, op_next;
    result_t                res_reg, res_next;

    logic                   ent_valid;
    logic [VAL_W-1:0]       ent_val;
    logic                   go;
    logic [NODE_W-1:0]      nn;

    function automatic logic [NIB_W-1:0] nib_of(input logic [KEY_BITS-1:0] k,
                                                 input logic [LW-1:0] lvl);
        logic [NIB_W-1:0] n;
        if (lvl == LW'(LEVELS)) begin
            n = k[KEY_BITS-1 -: NIB_W];
        end else begin
            n = NIB_W'(k >> {lvl, 2'b00});
        end
        return n;
    endfunction

    function automatic logic [HANDLE_W-1:0] out_handle(input logic [HANDLE_BITS-1:0] h);
        return HANDLE_W'(h[HIN-1:0]);
    endfunction

    assign ent_valid = ram_rd_data[VAL_W];
    assign ent_val   = ram_rd_data[VAL_W-1:0];

    always_comb begin
        state_next    = state_reg;
        lvl_next      = lvl_reg;
        node_next     = node_reg;
        free_next     = free_reg;
        clr_addr_next = clr_addr_reg;
        rd_addr_next  = rd_addr_reg;
        key_next      = key_reg;
        handle_next   = handle_reg;
        op_next       = op_reg;
        res_next      = res_reg;
        cmd_ready     = 1'b0;
        res_valid     = 1'b0;
        ram_wr_en     = 1'b0;
        ram_wr_addr   = rd_addr_reg;
        ram_wr_data   = '0;
        go            = 1'b0;
        nn            = node_reg;

        unique case (state_reg)
            S_CLEAR: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = clr_addr_reg;
                if (clr_addr_reg == AW'(DEPTH - 1)) begin
                    state_next = S_IDLE;
                end else begin
                    clr_addr_next = clr_addr_reg + 1'b1;
                end
            end

            S_IDLE: begin
                cmd_ready = 1'b1;
                if (cmd_valid) begin
                    key_next     = cmd_key;
                    handle_next  = cmd_handle;
                    op_next      = cmd_op;
                    lvl_next     = '0;
                    node_next    = '0;
                    rd_addr_next = {NODE_W'(0), cmd_key[NIB_W-1:0]};
                    state_next   = S_LOOKUP;
                end
            end

            S_LOOKUP: begin
                if (lvl_reg != LW'(LEVELS)) begin
                    if (ent_valid) begin
                        nn = ent_val[NODE_W-1:0];
                        go = 1'b1;
                    end else if (op_reg == OP_INSERT) begin
                        if (free_reg >= FW'(NODE_COUNT)) begin
                            res_next   = '{key: KEY_W'(key_reg),
                                           handle: out_handle(handle_reg),
                                           status: ST_POOL_FULL};
                            state_next = S_RESULT;
                        end else begin
                            // fresh node: its entries are still clear
                            ram_wr_en   = 1'b1;
                            ram_wr_data = {1'b1, VAL_W'(free_reg)};
                            free_next   = free_reg + 1'b1;
                            nn          = NODE_W'(free_reg);
                            go          = 1'b1;
                        end
                    end else begin
                        res_next   = '{key: KEY_W'(key_reg), handle: '0,
                                       status: ST_NOT_FOUND};
                        state_next = S_RESULT;
                    end
                    if (go) begin
                        node_next    = nn;
                        lvl_next     = LW'(lvl_reg + 1'b1);
                        rd_addr_next = {nn, nib_of(key_reg, LW'(lvl_reg + 1'b1))};
                    end
                end else begin
                    // leaf slot
                    state_next = S_RESULT;
                    if (op_reg == OP_INSERT) begin
                        if (ent_valid) begin
                            res_next = '{key: KEY_W'(key_reg),
                                         handle: out_handle(handle_reg),
                                         status: ST_EXISTS};
                        end else begin
                            ram_wr_en   = 1'b1;
                            ram_wr_data = {1'b1, VAL_W'(handle_reg)};
                            res_next    = '{key: KEY_W'(key_reg),
                                            handle: out_handle(handle_reg),
                                            status: ST_OK};
                        end
                    end else if (ent_valid) begin
                        res_next = '{key: KEY_W'(key_reg),
                                     handle: out_handle(ent_val[HANDLE_BITS-1:0]),
                                     status: ST_OK};
                        if (op_reg == OP_DISCARD) begin
                            ram_wr_en   = 1'b1;
                            ram_wr_data = '0;
                        end
                    end else begin
                        res_next = '{key: KEY_W'(key_reg), handle: '0,
                                     status: ST_NOT_FOUND};
                    end
                end
            end

            S_RESULT: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            lvl_reg      <= '0;
            node_reg     <= '0;
            free_reg     <= FW'(1);   // root preallocated
            clr_addr_reg <= '0;
            rd_addr_reg  <= '0;
        end else begin
            state_reg    <= state_next;
            lvl_reg      <= lvl_next;
            node_reg     <= node_next;
            free_reg     <= free_next;
            clr_addr_reg <= clr_addr_next;
            rd_addr_reg  <= rd_addr_next;
        end
        key_reg    <= key_next;
        handle_reg <= handle_next;
        op_reg     <= op_next;
        res_reg    <= res_next;
    end

    assign ram_rd_addr = rd_addr_next;
    assign res         = res_reg;

`ifndef NO_ASSERTIONS
    a_free_step: assert property (@(posedge aclk) disable iff (!aresetn)
        1'b1 |=> (free_reg == $past(free_reg)) || (free_reg == $past(free_reg) + 1'b1))
        else $error("node pool counter moved by more than one");

    a_retrieve_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (ram_wr_en && state_reg == S_LOOKUP && op_reg != OP_INSERT) |->
        (op_reg == OP_DISCARD && lvl_reg == LW'(LEVELS)))
        else $error("lookup wrote the trie outside a discard leaf");

    a_res_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && !res_ready) |=> (res_valid && $stable(res_reg)))
        else $error("pending result dropped or changed");

    a_lvl_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_LOOKUP) |-> (lvl_reg <= LW'(LEVELS)))
        else $error("walk level past leaf");
`endif

endmodule

`default_nettype wire

/* rtl/hashed_radix_trie_string_map_unit.sv */
`default_nettype none

// String interning map on a 16-ary radix trie keyed by a polynomial hash.
// Input stream (s_*): one transaction per insert byte, retrieve or discard.
//   s_tuser is the opcode, s_tlast marks the final byte of an insert string,
//   and the handle to store rides with that final byte.
// Output stream (m_*): at most one transaction per input transaction; a
//   non-final insert byte and opcode 3 produce none.
// Throughput: non-final insert bytes are taken one per cycle while the
//   walk is idle (hash update only). A final byte, retrieve or discard
//   walks the trie one level per cycle through the entry memory's
//   registered read port: (KEY_BITS-1)/4 + 1 levels (16 at KEY_BITS=64),
//   and the next transaction is taken only once the walk has handed its
//   result over to the output register.
// Reset: the hash accumulator clears, the node pool restarts at one (root
//   preallocated), and a clearing pass writes all 16*NODE_COUNT entries of
//   the memory (16384 by default), one per cycle. s_tready stays low until
//   it ends.
// Stall: a result waits in the output register while m_tready is low; the
//   block still accepts and works on the next transaction, holding its own
//   result until the output register frees up.
module hashed_radix_trie_string_map_unit
    import hrt_pkg::*;
#(
    parameter int KEY_BITS    = DEF_KEY_BITS,
    parameter int NODE_COUNT  = DEF_NODE_COUNT,
    parameter int HANDLE_BITS = DEF_HANDLE_BITS
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,   // data_byte, handle, key
    input  wire logic [OP_W-1:0]      s_tuser,   // op
    input  wire logic                 s_tlast,   // last
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic      [M_TDATA_W-1:0] m_tdata,   // key_out, handle_out
    output logic      [STATUS_W-1:0]  m_tuser    // status
);

    localparam int NODE_W = $clog2(NODE_COUNT);
    localparam int AW     = NODE_W + NIB_W;
    localparam int VAL_W  = (NODE_W > HANDLE_BITS) ? NODE_W : HANDLE_BITS;
    localparam int EW     = VAL_W + 1;
    localparam int HIN    = (HANDLE_BITS < HANDLE_W) ? HANDLE_BITS : HANDLE_W;

    // Input field unpacking
    logic [BYTE_W-1:0]   in_byte;
    logic [HANDLE_W-1:0] in_handle;
    logic [KEY_W-1:0]    in_key;
    logic                s_accept;
    logic                is_insert;

    assign in_byte   = s_tdata[BYTE_W-1:0];
    assign in_handle = s_tdata[BYTE_W +: HANDLE_W];
    assign in_key    = s_tdata[BYTE_W + HANDLE_W +: KEY_W];
    assign s_accept  = s_tvalid && s_tready;
    assign is_insert = (s_tuser == OP_INSERT);

    // Hash accumulator
    logic [KEY_BITS-1:0] h_next;

    hrt_hash #(
        .KEY_BITS (KEY_BITS)
    ) u_hash (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .take      (s_accept && is_insert),
        .clear     (s_tlast),
        .data_byte (in_byte),
        .h_next    (h_next)
    );

    // Trie walk: only final insert bytes, retrieves and discards reach it
    logic                   cmd_valid;
    logic                   cmd_ready;
    logic [KEY_BITS-1:0]    cmd_key;
    logic [HANDLE_BITS-1:0] cmd_handle;
    logic                   res_valid;
    logic                   res_ready;
    result_t                res;

    assign cmd_valid  = s_tvalid && ((is_insert && s_tlast) ||
                                     s_tuser == OP_RETRIEVE || s_tuser == OP_DISCARD);
    assign cmd_key    = is_insert ? h_next : in_key[KEY_BITS-1:0];
    assign cmd_handle = HANDLE_BITS'(in_handle[HIN-1:0]);
    assign s_tready   = cmd_ready;

    logic          ram_wr_en;
    logic [AW-1:0] ram_wr_addr;
    logic [EW-1:0] ram_wr_data;
    logic [AW-1:0] ram_rd_addr;
    logic [EW-1:0] ram_rd_data;

    hrt_walk #(
        .KEY_BITS    (KEY_BITS),
        .NODE_COUNT  (NODE_COUNT),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_walk (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .cmd_op      (op_t'(s_tuser)),
        .cmd_key     (cmd_key),
        .cmd_handle  (cmd_handle),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data)
    );

    // Entry memory: valid bit over child node number or handle
    hrt_ram #(
        .WIDTH (EW),
        .DEPTH (NODE_COUNT * 16)
    ) u_entries (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Output register
    logic    m_valid_reg;
    result_t m_res_reg;

    assign res_ready = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid && res_ready) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_res_reg.handle, m_res_reg.key};
    assign m_tuser  = m_res_reg.status;

endmodule

`default_nettype wire
